// File: hdl/sobm_pkg.sv
package sobm_pkg;

  localparam int PIX_W = 24;
  localparam int CHAN_W = 8;
  localparam int FW_W = 11;
  localparam int FH_W = 16;
  localparam int CFG_W = 16;
  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

  // register indexes
  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // squared magnitude above 255*255+255 rounds past 255
  localparam int SQ_W = 21;
  localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65280;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CHAN_W-1:0] chan_t;

endpackage

// File: hdl/sobm_line_ram.sv
module sobm_line_ram #(
  parameter int DEPTH = sobm_pkg::MAX_WIDTH_DEFAULT,
  parameter int ADDR_W = 10
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [2*sobm_pkg::PIX_W-1:0] wdata,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [2*sobm_pkg::PIX_W-1:0] rdata
);

  // {upper line, middle line} per column
  logic [2*sobm_pkg::PIX_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sobm_sqrt.sv
module sobm_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sobm_pkg::SQ_W-1:0]   n,
  output logic                        busy,
  output sobm_pkg::chan_t             root
);

  // two result bits per cycle while busy, eight result bits in all
  logic [15:0] nv;
  logic [9:0]  rem;
  logic [7:0]  res;
  logic [1:0]  cnt;
  logic        sat;
  logic [15:0] nv_next;
  logic [9:0]  rem_next;
  logic [7:0]  res_next;
  logic [10:0] t;
  logic [10:0] trial;
  logic [8:0]  rounded;

  always_comb begin
    nv_next = nv;
    rem_next = rem;
    res_next = res;
    t = '0;
    trial = '0;
    for (int k = 0; k < 2; k++) begin
      t = {rem_next[8:0], nv_next[15:14]};
      trial = {1'b0, res_next, 2'b01};
      if (t >= trial) begin
        rem_next = 10'(t - trial);
        res_next = {res_next[6:0], 1'b1};
      end else begin
        rem_next = 10'(t);
        res_next = {res_next[6:0], 1'b0};
      end
      nv_next = {nv_next[13:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= (n > sobm_pkg::SAT_LIMIT);
      nv <= n[15:0];
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      nv <= nv_next;
      rem <= rem_next;
      res <= res_next;
    end
  end

  // round half up: n > r*r + r  <=>  remainder > r
  assign rounded = {1'b0, res} + ((rem > {2'b00, res}) ? 9'd1 : 9'd0);
  assign root = sat ? 8'd255 : rounded[7:0];

endmodule

// File: hdl/sobel_edge_magnitude.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  op, in_red, in_green, in_blue
// out       output     out_valid / out_stall out_red, out_green, out_blue, frame_end
// cfg       input      cfg_we               cfg_index, cfg_data
//
// A pixel that yields a result passes accept, line read, window and
// gradients, squares, then the root stage (the 2-bit-per-cycle square
// root, then the load of the output register).
// A pixel with no result ends after the window step, a dropped item is
// discarded at accept; a flush that has to advance steps read and window twice.
// rst is synchronous; it clears counters and control, line contents are not
// cleared (entries outside the frame are masked). in_stall is high while an
// item is in work; a stalled result waits in the output register.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sobm_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  sobm_pkg::chan_t              in_red,
  input  sobm_pkg::chan_t              in_green,
  input  sobm_pkg::chan_t              in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sobm_pkg::chan_t              out_red,
  output sobm_pkg::chan_t              out_green,
  output sobm_pkg::chan_t              out_blue,
  output logic                         frame_end,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sobm_pkg::CFG_W-1:0]   cfg_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WID_W > sobm_pkg::FW_W) ? WID_W : sobm_pkg::FW_W;
  localparam int ROW_W = sobm_pkg::FH_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;

  logic [2:0] state;

  logic [sobm_pkg::FW_W-1:0] frame_width;
  logic [sobm_pkg::FH_W-1:0] frame_height;
  logic [CW-1:0]             eff_w;
  logic [sobm_pkg::FH_W-1:0] eff_h;

  // input and output positions
  logic [COL_W-1:0] ic;
  logic [ROW_W-1:0] ir;
  logic [COL_W-1:0] ocol;
  logic [sobm_pkg::FH_W-1:0] orow;

  sobm_pkg::pixel_t pix;
  logic             flush;
  logic             second;

  // last two columns of the 3x3 window: row 0 upper, row 2 newest
  sobm_pkg::pixel_t win [0:2][0:1];

  logic [2*sobm_pkg::PIX_W-1:0] rd;
  sobm_pkg::pixel_t top;
  sobm_pkg::pixel_t mid;

  logic draining;
  logic br_a;
  logic br_b;
  logic got;
  logic row0_ok;
  logic row2_ok;
  logic col0_ok;
  logic col2_ok;
  logic last;
  logic [CW-1:0] ic_inc;
  logic [CW-1:0] ocol_inc;

  sobm_pkg::chan_t nb [0:2][0:2][0:2];
  logic [9:0] gx_abs [0:2];
  logic [9:0] gy_abs [0:2];
  logic [9:0] mag_x [0:2];
  logic [9:0] mag_y [0:2];
  logic       last_reg;

  logic [sobm_pkg::SQ_W-1:0] sq [0:2];
  logic                      root_start;
  logic [2:0]                busy_ch;
  sobm_pkg::chan_t           root [0:2];

  always_comb begin
    if (frame_width == '0) begin
      eff_w = CW'(1);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    eff_h = (frame_height == '0) ? sobm_pkg::FH_W'(1) : frame_height;
  end

  assign draining = ir >= ROW_W'(eff_h);
  assign in_stall = (state != ST_IDLE);

  sobm_line_ram #(
    .DEPTH(MAX_WIDTH),
    .ADDR_W(COL_W)
  ) u_line (
    .clk(clk),
    .we(state == ST_CALC),
    .waddr(ic),
    .wdata({mid, pix}),
    .raddr(ic),
    .rdata(rd)
  );

  assign top = rd[2*sobm_pkg::PIX_W-1:sobm_pkg::PIX_W];
  assign mid = rd[sobm_pkg::PIX_W-1:0];

  // which output a step yields: row-end (br_a) or ordinary (br_b)
  always_comb begin
    br_a = (ic == '0) && (ir >= ROW_W'(2));
    br_b = (ic != '0) && (ir != '0);
    got = br_a || br_b;
    row0_ok = br_a ? (ir >= ROW_W'(3)) : (ir >= ROW_W'(2));
    row2_ok = br_a ? ((ir - ROW_W'(1)) < ROW_W'(eff_h)) : (ir < ROW_W'(eff_h));
    col0_ok = br_a ? (eff_w >= CW'(2)) : (CW'(ic) >= CW'(2));
    col2_ok = !br_a;
    ic_inc = CW'(ic) + CW'(1);
    ocol_inc = CW'(ocol) + CW'(1);
    last = ((ROW_W'(orow) + ROW_W'(1)) >= ROW_W'(eff_h)) && (ocol_inc >= eff_w);
  end

  // masked neighborhood, per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        nb[ch][r][0] = win[r][0][(2-ch)*8 +: 8];
        nb[ch][r][1] = win[r][1][(2-ch)*8 +: 8];
      end
      nb[ch][0][2] = top[(2-ch)*8 +: 8];
      nb[ch][1][2] = mid[(2-ch)*8 +: 8];
      nb[ch][2][2] = pix[(2-ch)*8 +: 8];
      for (int r = 0; r < 3; r++) begin
        if (!col0_ok) nb[ch][r][0] = '0;
        if (!col2_ok) nb[ch][r][2] = '0;
      end
      for (int c = 0; c < 3; c++) begin
        if (!row0_ok) nb[ch][0][c] = '0;
        if (!row2_ok) nb[ch][2][c] = '0;
      end
    end
  end

  always_comb begin
    logic [9:0] px;
    logic [9:0] nx;
    logic [9:0] py;
    logic [9:0] ny;
    for (int ch = 0; ch < 3; ch++) begin
      px = 10'(nb[ch][0][2]) + {1'b0, nb[ch][1][2], 1'b0} + 10'(nb[ch][2][2]);
      nx = 10'(nb[ch][0][0]) + {1'b0, nb[ch][1][0], 1'b0} + 10'(nb[ch][2][0]);
      py = 10'(nb[ch][2][0]) + {1'b0, nb[ch][2][1], 1'b0} + 10'(nb[ch][2][2]);
      ny = 10'(nb[ch][0][0]) + {1'b0, nb[ch][0][1], 1'b0} + 10'(nb[ch][0][2]);
      gx_abs[ch] = (px >= nx) ? (px - nx) : (nx - px);
      gy_abs[ch] = (py >= ny) ? (py - ny) : (ny - py);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frame_width <= sobm_pkg::FRAME_WIDTH_RESET;
      frame_height <= sobm_pkg::FRAME_HEIGHT_RESET;
      ic <= '0;
      ir <= '0;
      ocol <= '0;
      orow <= '0;
      out_valid <= 1'b0;
      second <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            second <= 1'b0;
            if ((op == sobm_pkg::OP_PIXEL && !draining) ||
                (op == sobm_pkg::OP_FLUSH && draining)) begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (ic_inc >= eff_w) begin
            ic <= '0;
            ir <= ir + ROW_W'(1);
          end else begin
            ic <= COL_W'(ic_inc);
          end
          if (got) begin
            if (ocol_inc >= eff_w) begin
              ocol <= '0;
              orow <= orow + sobm_pkg::FH_W'(1);
            end else begin
              ocol <= COL_W'(ocol_inc);
            end
            if (last) begin
              ic <= '0;
              ir <= '0;
              ocol <= '0;
              orow <= '0;
            end
            state <= ST_SQR;
          end else if (flush && !second) begin
            // a flush always drains one result: step once more
            second <= 1'b1;
            state <= ST_READ;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SQR: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (busy_ch == '0 && (!out_valid || !out_stall)) begin
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // the user writes only while idle (the block does not enforce it); any write restarts the frame
      if (cfg_we) begin
        case (cfg_index)
          sobm_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data[sobm_pkg::FW_W-1:0];
          sobm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[sobm_pkg::FH_W-1:0];
          default: frame_height <= frame_height;
        endcase
        ic <= '0;
        ir <= '0;
        ocol <= '0;
        orow <= '0;
      end
    end
  end

  // payload; a flush item steps the window with an empty pixel
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      pix <= (op == sobm_pkg::OP_FLUSH) ? '0 : {in_red, in_green, in_blue};
      flush <= op;
    end
    if (state == ST_CALC) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
      end
      win[0][1] <= top;
      win[1][1] <= mid;
      win[2][1] <= pix;
      for (int ch = 0; ch < 3; ch++) begin
        mag_x[ch] <= gx_abs[ch];
        mag_y[ch] <= gy_abs[ch];
      end
      last_reg <= last;
    end
    if (state == ST_ROOT && busy_ch == '0 && (!out_valid || !out_stall)) begin
      out_red <= root[0];
      out_green <= root[1];
      out_blue <= root[2];
      frame_end <= last_reg;
    end
  end

  assign root_start = (state == ST_SQR);

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    assign sq[ch] = sobm_pkg::SQ_W'(mag_x[ch]) * sobm_pkg::SQ_W'(mag_x[ch]) +
                    sobm_pkg::SQ_W'(mag_y[ch]) * sobm_pkg::SQ_W'(mag_y[ch]);
    sobm_sqrt u_sqrt (
      .clk(clk),
      .rst(rst),
      .start(root_start),
      .n(sq[ch]),
      .busy(busy_ch[ch]),
      .root(root[ch])
    );
  end

endmodule

// File: sim/sobel_edge_magnitude_tb.sv
module sobel_edge_magnitude_tb;

  localparam int LINE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 24;  // margin for the longest item, plus a doubled flush

  typedef struct packed {
    logic            op;
    sobm_pkg::chan_t red;
    sobm_pkg::chan_t green;
    sobm_pkg::chan_t blue;
  } pix_item_t;

  typedef struct packed {
    sobm_pkg::chan_t red;
    sobm_pkg::chan_t green;
    sobm_pkg::chan_t blue;
    logic            last;
  } edge_res_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic op;
  sobm_pkg::chan_t in_red, in_green, in_blue;
  logic out_valid;
  logic out_stall;
  sobm_pkg::chan_t out_red, out_green, out_blue;
  logic frame_end;
  logic cfg_we;
  logic cfg_index;
  logic [sobm_pkg::CFG_W-1:0] cfg_data;

  sobel_edge_magnitude dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .frame_end(frame_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // items waiting for the driver, edge results waiting for the monitor
  pix_item_t pending_items[$];
  edge_res_t expected_edges[$];
  int errors = 0;
  int items_queued = 0;
  int cycles = 0;
  bit calm = 0;  // no idling on either side while set

  // Predictor state: line buffers, 3x3 window, frame position counters
  sobm_pkg::pixel_t upper_line[LINE_DEPTH];
  sobm_pkg::pixel_t middle_line[LINE_DEPTH];
  sobm_pkg::pixel_t win[9];
  int in_col, in_row, out_col, out_row;
  int frame_w, frame_h;
  int kern_x[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  int kern_y[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  function automatic int eff_w();
    if (frame_w == 0) return 1;
    if (frame_w > LINE_DEPTH) return LINE_DEPTH;
    return frame_w;
  endfunction

  function automatic int eff_h();
    return (frame_h == 0) ? 1 : frame_h;
  endfunction

  // round(sqrt(n)) clamped to 255; anything past 255*255+255 saturates
  function automatic sobm_pkg::chan_t round_root(int n);
    int r;
    if (n > 65280) return 8'd255;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    if (n > r * r + r) r++;
    return r[7:0];
  endfunction

  function automatic sobm_pkg::chan_t chan_mag(sobm_pkg::pixel_t nb[9], bit ok[9], int sh);
    int gx, gy, v;
    gx = 0;
    gy = 0;
    for (int i = 0; i < 9; i++) begin
      if (ok[i]) begin
        v = (nb[i] >> sh) & 255;
        gx += kern_x[i] * v;
        gy += kern_y[i] * v;
      end
    end
    return round_root(gx * gx + gy * gy);
  endfunction

  // one shift of the window at the current input position
  function automatic bit sobel_shift(sobm_pkg::pixel_t pix, output edge_res_t res);
    int w, h, ir, ic;
    sobm_pkg::pixel_t nb[9];
    bit ok[9];
    bit rowok[3], colok[3];
    bit got, last;
    sobm_pkg::pixel_t top, mid;
    w = eff_w();
    h = eff_h();
    ir = in_row;
    ic = in_col;
    got = 0;
    res = '0;
    // row start: finish the last pixel of the previous row
    if (ic == 0 && ir >= 2) begin
      rowok[0] = ir >= 3; rowok[1] = 1; rowok[2] = (ir - 1) < h;
      colok[0] = w >= 2;  colok[1] = 1; colok[2] = 0;
      for (int r = 0; r < 3; r++) begin
        nb[r*3]   = win[r*3+1];
        nb[r*3+1] = win[r*3+2];
        nb[r*3+2] = '0;
        for (int c = 0; c < 3; c++) ok[r*3+c] = rowok[r] && colok[c];
      end
      got = 1;
    end
    if (ic < LINE_DEPTH) begin
      top = upper_line[ic];
      mid = middle_line[ic];
      upper_line[ic] = mid;
      middle_line[ic] = pix;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;
    end
    if (ic >= 1 && ir >= 1) begin
      rowok[0] = ir >= 2; rowok[1] = 1; rowok[2] = ir < h;
      colok[0] = ic >= 2; colok[1] = 1; colok[2] = 1;
      for (int i = 0; i < 9; i++) begin
        nb[i] = win[i];
        ok[i] = rowok[i/3] && colok[i%3];
      end
      got = 1;
    end
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
    end
    in_col = ic;
    in_row = ir;
    if (got) begin
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.red = chan_mag(nb, ok, 16);
      res.green = chan_mag(nb, ok, 8);
      res.blue = chan_mag(nb, ok, 0);
      res.last = last;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (last) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
    end
    return got;
  endfunction

  function automatic bit draining();
    return in_row >= eff_h();
  endfunction

  // queue one item and record the edge result it should produce
  function automatic void push_item(logic kind, sobm_pkg::chan_t r, sobm_pkg::chan_t g,
                                    sobm_pkg::chan_t b);
    pix_item_t it;
    edge_res_t res;
    bit got;
    it = '{op: kind, red: r, green: g, blue: b};
    pending_items.push_back(it);
    items_queued++;
    got = 0;
    if (kind == sobm_pkg::OP_PIXEL) begin
      if (!draining()) got = sobel_shift({r, g, b}, res);
    end else if (draining()) begin
      got = sobel_shift('0, res);
      if (!got) got = sobel_shift('0, res);
    end
    if (got) expected_edges.push_back(res);
  endfunction

  function automatic sobm_pkg::chan_t rand_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return sobm_pkg::chan_t'($urandom);
    endcase
  endfunction

  // drain with flushes, now and then a pixel that must be dropped
  function automatic void drain_frame(int noise_pct);
    while (draining()) begin
      if ($urandom_range(0, 99) < noise_pct)
        push_item(sobm_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      else
        push_item(sobm_pkg::OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: next item goes out once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
        pix_item_t it;
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        op <= it.op;
        in_red <= it.red;
        in_green <= it.green;
        in_blue <= it.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, compare each taken result with the oldest expected
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 38);
      if (out_valid && !out_stall) begin
        if (expected_edges.size() == 0) begin
          $error("unexpected result red=%0d green=%0d blue=%0d frame_end=%0b",
                 out_red, out_green, out_blue, frame_end);
          errors++;
        end else begin
          edge_res_t e;
          e = expected_edges.pop_front();
          if (out_red !== e.red) begin
            $error("out_red expected %0d got %0d", e.red, out_red);
            errors++;
          end
          if (out_green !== e.green) begin
            $error("out_green expected %0d got %0d", e.green, out_green);
            errors++;
          end
          if (out_blue !== e.blue) begin
            $error("out_blue expected %0d got %0d", e.blue, out_blue);
            errors++;
          end
          if (frame_end !== e.last) begin
            $error("frame_end expected %0b got %0b", e.last, frame_end);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sobel_edge_magnitude");
      $finish;
    end
  end

  // wait until the block has taken everything and returned every result
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_edges.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; also restarts the predictor's frame
  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[sobm_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sobm_pkg::REG_FRAME_WIDTH) frame_w = value & 'h7ff;
    else frame_h = value & 'hffff;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic set_frame(int w, int h);
    write_reg(sobm_pkg::REG_FRAME_WIDTH, w);
    write_reg(sobm_pkg::REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int w, h, n;
    rst = 1'b1;
    in_valid = 1'b0;
    op = sobm_pkg::OP_PIXEL;
    in_red = '0; in_green = '0; in_blue = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sobm_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    frame_w = int'(sobm_pkg::FRAME_WIDTH_RESET);
    frame_h = int'(sobm_pkg::FRAME_HEIGHT_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3 checkerboard of extremes: flush mid-frame is ignored, a pixel
    // in the drain is dropped
    set_frame(3, 3);
    push_item(sobm_pkg::OP_FLUSH, 8'd255, 8'd255, 8'd255);
    for (int i = 0; i < 9; i++)
      push_item(sobm_pkg::OP_PIXEL, (i % 2) ? 8'd255 : 8'd0, (i % 2) ? 8'd0 : 8'd255,
                8'd255);
    push_item(sobm_pkg::OP_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(sobm_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd255);
    drain_frame(0);
    wait_idle();

    // zero registers act as 1x1
    set_frame(0, 0);
    push_item(sobm_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd255);
    drain_frame(0);
    wait_idle();

    // single column, then single row (flush that advances twice)
    set_frame(1, 4);
    for (int i = 0; i < 4; i++) push_item(sobm_pkg::OP_PIXEL, 8'd255, 8'd0, 8'd128);
    drain_frame(0);
    wait_idle();
    set_frame(5, 1);
    for (int i = 0; i < 5; i++)
      push_item(sobm_pkg::OP_PIXEL, sobm_pkg::chan_t'(i * 60),
                sobm_pkg::chan_t'(255 - i * 60), 8'd255);
    drain_frame(0);
    wait_idle();

    // widest setting clamps to the line depth; a partial frame is abandoned
    set_frame(2047, 2);
    for (int i = 0; i < 12; i++)
      push_item(sobm_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
    wait_idle();
    set_frame(1, 65535);
    for (int i = 0; i < 12; i++)
      push_item(sobm_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
    wait_idle();

    // random frames, mostly small
    n = 0;
    while (items_queued < 940) begin
      calm = (n == 6 || n == 7);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_frame(w, h);
      if ($urandom_range(0, 9) == 0) begin
        // abandoned frame
        for (int i = $urandom_range(1, w * h); i > 0; i--)
          push_item(sobm_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
      end else begin
        for (int f = $urandom_range(1, 2); f > 0; f--) begin
          while (!draining()) begin
            if ($urandom_range(0, 99) < 5)
              push_item(sobm_pkg::OP_FLUSH, rand_chan(), rand_chan(), rand_chan());
            else
              push_item(sobm_pkg::OP_PIXEL, rand_chan(), rand_chan(), rand_chan());
          end
          drain_frame(8);
        end
      end
      wait_idle();
      n++;
    end
    calm = 0;

    wait_idle();
    if (errors == 0)
      $display("PASS sobel_edge_magnitude");
    else
      $display("FAIL sobel_edge_magnitude");
    $finish;
  end

endmodule

// File: sobel_edge_magnitude.f
hdl/sobm_pkg.sv
hdl/sobm_line_ram.sv
hdl/sobm_sqrt.sv
hdl/sobel_edge_magnitude.sv
sim/sobel_edge_magnitude_tb.sv
